// File: sv/brwlt_pkg.sv
`timescale 1ns / 1ps
package brwlt_pkg;

  // Field widths of the request and result words
  localparam int unsigned OP_W       = 2;
  localparam int unsigned BUCKET_W   = 6;
  localparam int unsigned RELEASED_W = 8;

  // Table geometry
  localparam int unsigned BUCKETS   = 64;
  localparam int unsigned COUNT_MAX = 255;
  localparam int unsigned IDX_W     = $clog2(BUCKETS);
  localparam int unsigned CNT_W     = $clog2(COUNT_MAX + 1);

  // Request queue between front and back; depth must be a power of two
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_MAX = CNT_W'(COUNT_MAX);

  typedef enum logic [OP_W-1:0] {
    OP_START_READ  = 2'd0,
    OP_END_READ    = 2'd1,
    OP_START_WRITE = 2'd2,
    OP_END_WRITE   = 2'd3
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_e;

  // Classified request as it travels through the queue
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             oob;
  } req_t;

  // One bucket entry of the lock table
  typedef struct packed {
    cnt_t active_readers;
    logic write_active;
    cnt_t waiting_readers;
    cnt_t waiting_writers;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned REQ_W   = $bits(req_t);

endpackage

// File: sv/brwlt_ram.sv
`timescale 1ns / 1ps
module brwlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/brwlt_front.sv
`timescale 1ns / 1ps
module brwlt_front import brwlt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [BUCKET_W-1:0] bucket_i,
  output logic                push_o,
  output req_t                push_req_o,
  input  logic                fifo_full_i
);

  logic hold_q, hold_d;
  req_t req_q;
  req_t req_cls;
  logic accept;

  // decode op, range-check bucket
  always_comb begin
    req_cls.op  = op_e'(operation_i);
    req_cls.idx = IDX_W'(bucket_i);
    req_cls.oob = (32'(bucket_i) >= 32'(BUCKETS));
  end

  assign in_stall_o = hold_q && fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = hold_q && !fifo_full_i;
  assign push_req_o = req_q;

  always_comb begin
    hold_d = hold_q;
    if (accept) begin
      hold_d = 1'b1;
    end else if (push_o) begin
      hold_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_cls;
    end
  end

endmodule

// File: sv/brwlt_fifo.sv
`timescale 1ns / 1ps
module brwlt_fifo import brwlt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t push_req_i,
  output logic full_o,
  input  logic pop_i,
  output req_t head_o,
  output logic empty_o
);

  req_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_req_i;
    end
  end

endmodule

// File: sv/brwlt_back.sv
`timescale 1ns / 1ps
module brwlt_back import brwlt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fifo_empty_i,
  input  req_t                  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [RELEASED_W-1:0] readers_released_o,
  output logic                  writer_released_o,
  output logic                  misuse_o
);

  back_state_e state_q, state_d;
  req_t        req_q;
  logic        ent_vld_q;
  logic        vld_q [BUCKETS];
  logic        ovld_q, ovld_d;

  logic [ENTRY_W-1:0] rdata;
  entry_t ent, nxt;
  cnt_t   room, nrel;
  logic   res_grant, res_wrel, res_misuse;
  logic [RELEASED_W-1:0] res_rel;
  logic   fire, out_free;

  brwlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (fire && !req_q.oob),
    .waddr_i (req_q.idx),
    .wdata_i (nxt),
    .re_i    (pop_o),
    .raddr_i (head_i.idx),
    .rdata_o (rdata)
  );

  assign out_free = !ovld_q || !out_stall_i;

  // next state / control
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    fire    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          fire    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // entry update; never-written buckets read as zero
  always_comb begin
    ent        = ent_vld_q ? entry_t'(rdata) : '0;
    nxt        = ent;
    res_grant  = 1'b0;
    res_wrel   = 1'b0;
    res_misuse = 1'b0;
    res_rel    = '0;
    room       = CNT_MAX - ent.active_readers;
    nrel       = (ent.waiting_readers > room) ? room : ent.waiting_readers;
    if (req_q.oob) begin
      res_misuse = 1'b1;
    end else begin
      case (req_q.op)
        OP_START_READ: begin
          if (ent.write_active || ent.waiting_writers != '0) begin
            if (ent.waiting_readers >= CNT_MAX) res_misuse = 1'b1;
            else nxt.waiting_readers = ent.waiting_readers + 1'b1;
          end else begin
            if (ent.active_readers >= CNT_MAX) begin
              res_misuse = 1'b1;
            end else begin
              nxt.active_readers = ent.active_readers + 1'b1;
              res_grant          = 1'b1;
            end
          end
        end
        OP_END_READ: begin
          if (ent.active_readers == '0) begin
            res_misuse = 1'b1;
          end else begin
            nxt.active_readers = ent.active_readers - 1'b1;
            // last reader out hands over to one waiting writer
            if (ent.active_readers == CNT_W'(1) && ent.waiting_writers != '0) begin
              nxt.write_active    = 1'b1;
              nxt.waiting_writers = ent.waiting_writers - 1'b1;
              res_wrel            = 1'b1;
            end
          end
        end
        OP_START_WRITE: begin
          if (ent.write_active || ent.active_readers != '0
              || ent.waiting_readers != '0) begin
            if (ent.waiting_writers >= CNT_MAX) res_misuse = 1'b1;
            else nxt.waiting_writers = ent.waiting_writers + 1'b1;
          end else begin
            nxt.write_active = 1'b1;
            res_grant        = 1'b1;
          end
        end
        OP_END_WRITE: begin
          if (!ent.write_active) begin
            res_misuse = 1'b1;
          end else begin
            nxt.write_active = 1'b0;
            if (ent.waiting_readers != '0) begin
              // admit readers as far as the active count has room
              nxt.active_readers  = ent.active_readers + nrel;
              nxt.waiting_readers = ent.waiting_readers - nrel;
              res_rel = (32'(nrel) > 32'(2**RELEASED_W - 1)) ? '1 : RELEASED_W'(nrel);
            end else if (ent.waiting_writers != '0) begin
              nxt.write_active    = 1'b1;
              nxt.waiting_writers = ent.waiting_writers - 1'b1;
              res_wrel            = 1'b1;
            end
          end
        end
        default: res_misuse = 1'b1;
      endcase
    end
  end

  always_comb begin
    ovld_d = ovld_q;
    if (fire) begin
      ovld_d = 1'b1;
    end else if (!out_stall_i) begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ovld_q  <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (fire && !req_q.oob) begin
        vld_q[req_q.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      req_q     <= head_i;
      ent_vld_q <= vld_q[head_i.idx];
    end
    if (fire) begin
      granted_o          <= res_grant;
      readers_released_o <= res_rel;
      writer_released_o  <= res_wrel;
      misuse_o           <= res_misuse;
    end
  end

  assign out_valid_o = ovld_q;

endmodule

// File: sv/bucket_readers_writers_lock_table.sv
`timescale 1ns / 1ps
// Readers-writer lock table, one lock per bucket, writer preference.
// Input channel: in_valid_i / in_stall_o with operation_i (start read,
//   end read, start write, end write) and bucket_i. A word is taken at a
//   rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with granted_o,
//   readers_released_o, writer_released_o and misuse_o; exactly one result
//   word per request, in request order.
// Front: an input register that decodes the operation and range-checks the
//   bucket, feeding a two-entry queue. Back: reads the bucket entry from
//   a RAM, updates it and writes it back, then loads the result register.
// Flow: the back takes one word at a time; its entry read (registered RAM
//   read) is followed by the update and write-back of the same entry.
// Path: a request passes the front register, the queue, the back's entry
//   read and the result register.
// Reset: all buckets read as zero at once (per-bucket valid flags), no
//   clearing pass; queue and output register are emptied.
// Output stall: the result word holds; the back waits, the queue fills and
//   in_stall_o rises once the front register also holds a word.
module bucket_readers_writers_lock_table import brwlt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [BUCKET_W-1:0]   bucket_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  granted_o,
  output logic [RELEASED_W-1:0] readers_released_o,
  output logic                  writer_released_o,
  output logic                  misuse_o
);

  logic fifo_push, fifo_pop, fifo_full, fifo_empty;
  req_t push_req, head_req;

  brwlt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .bucket_i    (bucket_i),
    .push_o      (fifo_push),
    .push_req_o  (push_req),
    .fifo_full_i (fifo_full)
  );

  brwlt_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fifo_push),
    .push_req_i (push_req),
    .full_o     (fifo_full),
    .pop_i      (fifo_pop),
    .head_o     (head_req),
    .empty_o    (fifo_empty)
  );

  brwlt_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fifo_empty_i       (fifo_empty),
    .head_i             (head_req),
    .pop_o              (fifo_pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .granted_o          (granted_o),
    .readers_released_o (readers_released_o),
    .writer_released_o  (writer_released_o),
    .misuse_o           (misuse_o)
  );

  // Back never pops an empty queue, front never pushes a full one
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty) else $error("pop from empty queue");

  a_push_notfull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full) else $error("push into full queue");

  // A misused request changes nothing and reports nothing else
  a_misuse_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && misuse_o |->
      !granted_o && !writer_released_o && readers_released_o == '0)
    else $error("misuse word carries other results");

  // Readers and a writer are never released by the same request
  a_release_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && readers_released_o != '0 |-> !writer_released_o && !granted_o)
    else $error("readers and writer released together");

endmodule

// File: tb/sv/lock_table_scoreboard_pkg.sv
`timescale 1ns / 1ps
package lock_table_scoreboard_pkg;
  import brwlt_pkg::*;

  // What one request word should produce on the result channel
  typedef struct packed {
    logic                  granted;
    logic [RELEASED_W-1:0] released;
    logic                  writer_released;
    logic                  misuse;
  } lock_outcome_t;

  class lock_scoreboard;
    cnt_t          readers_held   [BUCKETS];
    logic          writer_holds   [BUCKETS];
    cnt_t          readers_queued [BUCKETS];
    cnt_t          writers_queued [BUCKETS];
    lock_outcome_t outcomes_due[$];
    int unsigned   errors, words_checked, grants, batches, handoffs, misuses;

    function new();
      for (int i = 0; i < BUCKETS; i++) begin
        readers_held[i]   = '0;
        writer_holds[i]   = 1'b0;
        readers_queued[i] = '0;
        writers_queued[i] = '0;
      end
      errors        = 0;
      words_checked = 0;
      grants        = 0;
      batches       = 0;
      handoffs      = 0;
      misuses       = 0;
    endfunction

    // Apply one accepted request to the lock table copy, queue its outcome
    function void note_request(op_e op, logic [BUCKET_W-1:0] bucket);
      lock_outcome_t o;
      int unsigned   i;
      int unsigned   room;
      int unsigned   n;
      o = '0;
      i = 32'(bucket);
      if (i >= BUCKETS) begin
        o.misuse = 1'b1;
      end else begin
        case (op)
          OP_START_READ: begin
            if (writer_holds[i] || writers_queued[i] != 0) begin
              if (readers_queued[i] >= CNT_MAX) o.misuse = 1'b1;
              else readers_queued[i]++;
            end else if (readers_held[i] >= CNT_MAX) begin
              o.misuse = 1'b1;
            end else begin
              readers_held[i]++;
              o.granted = 1'b1;
            end
          end
          OP_END_READ: begin
            if (readers_held[i] == 0) begin
              o.misuse = 1'b1;
            end else begin
              readers_held[i]--;
              if (readers_held[i] == 0 && writers_queued[i] != 0) begin
                writer_holds[i] = 1'b1;
                writers_queued[i]--;
                o.writer_released = 1'b1;
              end
            end
          end
          OP_START_WRITE: begin
            if (writer_holds[i] || readers_held[i] != 0 || readers_queued[i] != 0) begin
              if (writers_queued[i] >= CNT_MAX) o.misuse = 1'b1;
              else writers_queued[i]++;
            end else begin
              writer_holds[i] = 1'b1;
              o.granted       = 1'b1;
            end
          end
          OP_END_WRITE: begin
            if (!writer_holds[i]) begin
              o.misuse = 1'b1;
            end else begin
              writer_holds[i] = 1'b0;
              if (readers_queued[i] != 0) begin
                // readers go in together, as far as the held count has room
                room = COUNT_MAX - readers_held[i];
                n    = readers_queued[i];
                if (n > room) n = room;
                readers_held[i]   += cnt_t'(n);
                readers_queued[i] -= cnt_t'(n);
                o.released = (n > 255) ? 8'd255 : n[RELEASED_W-1:0];
              end else if (writers_queued[i] != 0) begin
                writer_holds[i] = 1'b1;
                writers_queued[i]--;
                o.writer_released = 1'b1;
              end
            end
          end
        endcase
      end
      outcomes_due.push_back(o);
    endfunction

    function void compare_field(string what, logic [7:0] due, logic [7:0] seen);
      if (due !== seen) begin
        errors++;
        $display("%0t: word %0d %s expected %0d, actual %0d",
                 $time, words_checked, what, due, seen);
      end
    endfunction

    // Compare one accepted result word with the oldest outcome due
    function void check_result(logic granted, logic [RELEASED_W-1:0] released,
                               logic writer_released, logic misuse);
      lock_outcome_t o;
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing due: expected none, actual %0b/%0d/%0b/%0b",
                 $time, granted, released, writer_released, misuse);
        return;
      end
      o = outcomes_due.pop_front();
      compare_field("granted", o.granted, granted);
      compare_field("readers_released", o.released, released);
      compare_field("writer_released", o.writer_released, writer_released);
      compare_field("misuse", o.misuse, misuse);
      words_checked++;
      if (o.granted) grants++;
      if (o.released != 0) batches++;
      if (o.writer_released) handoffs++;
      if (o.misuse) misuses++;
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Lock table bench: a short hand-written sequence, two saturation floods,
// then random requests. Every accepted request word goes through the
// scoreboard's own lock table copy; every result word is checked against it.
module testbench;
  import brwlt_pkg::*;
  import lock_table_scoreboard_pkg::*;

  // Cycle limit for the watchdog
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 1150;
  // A few past the counter ceiling so the saturation guard is hit
  localparam int unsigned FLOOD_WORDS  = COUNT_MAX + 3;

  localparam logic [BUCKET_W-1:0] LOW_BUCKET  = '0;
  localparam logic [BUCKET_W-1:0] HIGH_BUCKET = '1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [BUCKET_W-1:0]   bucket_i    = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  granted_o;
  logic [RELEASED_W-1:0] readers_released_o;
  logic                  writer_released_o;
  logic                  misuse_o;

  lock_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  // receiver stall pattern state
  int unsigned stall_mode  = 0;
  int unsigned stall_phase = 0;
  int unsigned run_left    = 0;
  bit          run_stalled = 1'b0;

  bucket_readers_writers_lock_table uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request word and hold it until the block takes it. Words come
  // in bursts; at the end of a burst valid drops for a random gap, but only
  // when the gap is non-zero, so valid never falls and rises in one step.
  task automatic send_word(input op_e op, input logic [BUCKET_W-1:0] bucket);
    int unsigned gap;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    bucket_i    <= bucket;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(op, bucket);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Result side: check on accepted words, then pick next cycle's stall.
  // Modes: never stall, scattered stalls, or long stall/free runs.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i)
      sb.check_result(granted_o, readers_released_o, writer_released_o, misuse_o);
    if (stall_phase == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_phase = $urandom_range(50, 300);
    end else begin
      stall_phase--;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_stalled = !run_stalled;
          run_left    = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 6);
        end else begin
          run_left--;
        end
        out_stall_i <= run_stalled;
      end
    endcase
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d result words still due",
               $time, sb.outcomes_due.size());
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    op_e                 op;
    logic [BUCKET_W-1:0] bucket;
    logic [BUCKET_W-1:0] flood_a;
    logic [BUCKET_W-1:0] flood_b;
    logic [BUCKET_W-1:0] hot [4];
    op_e                 choice[$];

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(0, 24);

    // Hand-written part on the lowest and highest bucket
    send_word(OP_END_READ, LOW_BUCKET);      // end read with no reader held
    send_word(OP_END_WRITE, HIGH_BUCKET);    // end write with no writer
    send_word(OP_START_READ, LOW_BUCKET);
    send_word(OP_START_READ, LOW_BUCKET);
    send_word(OP_START_WRITE, LOW_BUCKET);   // queued behind two readers
    send_word(OP_START_READ, LOW_BUCKET);    // queued: writer preference
    send_word(OP_END_READ, LOW_BUCKET);
    send_word(OP_END_READ, LOW_BUCKET);      // last reader hands to writer
    send_word(OP_START_WRITE, LOW_BUCKET);   // queued behind active write
    send_word(OP_END_WRITE, LOW_BUCKET);     // waiting reader goes first
    send_word(OP_END_READ, LOW_BUCKET);      // then the queued writer
    send_word(OP_END_WRITE, LOW_BUCKET);
    send_word(OP_START_WRITE, HIGH_BUCKET);
    send_word(OP_START_WRITE, HIGH_BUCKET);
    send_word(OP_END_WRITE, HIGH_BUCKET);    // writer to writer
    send_word(OP_END_WRITE, HIGH_BUCKET);
    send_word(OP_END_WRITE, HIGH_BUCKET);    // nothing held any more
    send_word(OP_START_READ, HIGH_BUCKET);
    send_word(OP_END_READ, HIGH_BUCKET);
    send_word(OP_END_READ, HIGH_BUCKET);

    // Floods on two untouched buckets: fill the reader queue, then the
    // writer queue, release a full batch of readers in one go, and push the
    // held reader count of a free bucket up against its ceiling.
    flood_a = BUCKET_W'($urandom_range(1, BUCKETS - 2));
    flood_b = BUCKET_W'((flood_a % (BUCKETS - 2)) + 1);
    send_word(OP_START_WRITE, flood_a);
    repeat (FLOOD_WORDS) send_word(OP_START_READ, flood_a);
    repeat (FLOOD_WORDS) send_word(OP_START_WRITE, flood_a);
    send_word(OP_END_WRITE, flood_a);
    repeat (FLOOD_WORDS) send_word(OP_START_READ, flood_b);

    // Random part: mostly requests that make sense for the bucket's state,
    // on a small hot set so locks build up and hand over; the rest is noise.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 128 == 0)
        foreach (hot[k]) hot[k] = BUCKET_W'($urandom_range(0, BUCKETS - 1));
      if ($urandom_range(0, 9) < 6) bucket = hot[$urandom_range(0, 3)];
      else bucket = BUCKET_W'($urandom_range(0, BUCKETS - 1));
      if ($urandom_range(0, 4) == 0) begin
        op = op_e'($urandom_range(0, 3));
      end else begin
        choice.delete();
        choice.push_back(OP_START_READ);
        choice.push_back(OP_START_WRITE);
        // ends weighted up so held locks drain again
        if (sb.readers_held[bucket] != 0) begin
          choice.push_back(OP_END_READ);
          choice.push_back(OP_END_READ);
        end
        if (sb.writer_holds[bucket]) begin
          choice.push_back(OP_END_WRITE);
          choice.push_back(OP_END_WRITE);
        end
        op = choice[$urandom_range(0, choice.size() - 1)];
      end
      send_word(op, bucket);
    end
    in_valid_i <= 1'b0;

    while (sb.outcomes_due.size() != 0) @(posedge clk_i);
    // a stray late word would show up here
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d request words: %0d granted, %0d reader batches, %0d writer hand-offs,",
             sb.words_checked, sb.grants, sb.batches, sb.handoffs);
    $display("%0d flagged as misuse; counters driven to saturation on buckets %0d and %0d.",
             sb.misuses, flood_a, flood_b);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
